### rtl/prrtp_pkg.sv
// Shared types and codes for the priority round-robin task picker.
// Depends on nothing; every other file imports it.
package prrtp_pkg;

  localparam int DEFAULT_TASK_SLOTS = 16;
  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 4;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [ACT_W-1:0] ACT_SCHEDULE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SLEEP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_YIELD    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ID_TAKEN  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NONE      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_USED  = 3'd4;

  // A running task is held as ready: the two are never told apart.
  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_WAIT  = 2'd2,
    SLOT_YIELD = 2'd3
  } slot_state_t;

  typedef struct packed {
    slot_state_t             state;
    logic [ID_W-1:0]         id;
    logic [PRI_W-1:0]        priority_lvl;
    logic [TIME_W-1:0]       wake;
  } entry_t;

endpackage

### rtl/prrtp_if.sv
// Request and response channel interfaces of the task picker.
// Depends on prrtp_pkg for field widths.
interface prrtp_req_if
  import prrtp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ID_W-1:0]   task_id;
  logic [PRI_W-1:0]  task_priority;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] now_us;
  logic [TIME_W-1:0] duration_us;
  modport source (output valid, action, task_id, task_priority, slot, now_us, duration_us,
                  input ready);
  modport sink (input valid, action, task_id, task_priority, slot, now_us, duration_us,
                output ready);
endinterface

interface prrtp_rsp_if
  import prrtp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] chosen_slot;
  logic [ID_W-1:0]   chosen_id;
  logic [PRI_W-1:0]  chosen_priority;
  modport source (output valid, status, chosen_slot, chosen_id, chosen_priority,
                  input ready);
  modport sink (input valid, status, chosen_slot, chosen_id, chosen_priority,
                output ready);
endinterface

### rtl/prrtp_cell.sv
// One task slot cell of the rotating ring.
// Depends on prrtp_pkg for the entry type.
module prrtp_cell
  import prrtp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t from_next,
  input  logic   wr,
  input  entry_t wr_data,
  output entry_t q
);

  // Shift loads the neighbor's entry; a write applies only when not shifting.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.state <= SLOT_FREE;
    end else if (shift) begin
      q <= from_next;
    end else if (wr) begin
      q <= wr_data;
    end
  end

endmodule

### rtl/priority_round_robin_task_picker.sv
// Top level of the priority round-robin task picker.
// Depends on prrtp_pkg, prrtp_if and prrtp_cell.
//
// The task table lives in a ring of TASK_SLOTS cells. Each request transaction
// rotates the ring once all the way around, one cell per clock, so every slot
// passes the head cell exactly once and the ring ends aligned again. The head
// logic applies the action to the slot passing by (wake test, yield release,
// remove, sleep or yield mark, duplicate and free search, best pick) and feeds
// the updated entry into the tail. A new task is written into its free slot in
// the cycle after the rotation. A transaction passes from acceptance through the
// scan, finish and hold states to a registered response. The response sits in
// an output register, and a new request is taken while a response still waits
// to be taken. The running task is kept as a ready entry plus the current slot
// register.
module priority_round_robin_task_picker
  import prrtp_pkg::*;
#(
  parameter int TASK_SLOTS = DEFAULT_TASK_SLOTS
) (
  input logic          clk,
  input logic          rst,
  prrtp_req_if.sink    req,
  prrtp_rsp_if.source  rsp
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = (SW > SLOT_W) ? SW : SLOT_W;
  localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_HOLD
  } fsm_t;

  fsm_t state;

  // Captured request.
  logic [ACT_W-1:0]  op_action;
  logic [ID_W-1:0]   op_id;
  logic [PRI_W-1:0]  op_pri;
  logic [SLOT_W-1:0] op_slot;
  logic [TIME_W-1:0] op_now;
  logic [TIME_W-1:0] op_wake;

  logic [SW-1:0] step;
  logic [SW-1:0] cur_slot;
  logic          cur_valid;

  // Results gathered while the ring turns.
  logic             found;
  logic [SW-1:0]    best;
  logic [SW-1:0]    best_dist;
  logic [ID_W-1:0]  best_id;
  logic [PRI_W-1:0] best_pri;
  logic             free_found;
  logic [SW-1:0]    free_slot;
  logic             dup;
  logic             hit;
  logic [ID_W-1:0]  hit_id;
  logic [PRI_W-1:0] hit_pri;

  // Response waiting for the output register.
  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [ID_W-1:0]   res_id;
  logic [PRI_W-1:0]  res_pri;

  entry_t ring_q [TASK_SLOTS];
  entry_t head;
  entry_t head_next;
  entry_t new_entry;
  logic   shift;
  logic   add_wr;

  logic              wait_due;
  logic [TIME_W-1:0] wake_diff;
  logic [SW:0]       dist_wide;
  logic [SW-1:0]     rr_dist;
  logic              eligible;
  logic              better;
  logic              slot_match;
  logic              cur_match;

  assign head  = ring_q[0];
  assign shift = (state == ST_SCAN);

  assign new_entry.state        = SLOT_READY;
  assign new_entry.id           = op_id;
  assign new_entry.priority_lvl = op_pri;
  assign new_entry.wake         = '0;

  assign add_wr = (state == ST_FINISH) && (op_action == ACT_ADD) && free_found && !dup;

  genvar k;
  generate
    for (k = 0; k < TASK_SLOTS; k++) begin : g_cell
      entry_t nb;
      if (k == TASK_SLOTS - 1) begin : g_tail
        assign nb = head_next;
      end else begin : g_mid
        assign nb = ring_q[k+1];
      end
      prrtp_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .from_next(nb),
        .wr       (add_wr && (free_slot == SW'(k))),
        .wr_data  (new_entry),
        .q        (ring_q[k])
      );
    end
  endgenerate

  // Head cell: the slot numbered step passes here in this cycle.
  always_comb begin
    wake_diff  = head.wake - op_now;
    wait_due   = (head.state == SLOT_WAIT) && ((wake_diff == '0) || wake_diff[TIME_W-1]);
    // Distance in round-robin order from the slot after the current one.
    if (step > cur_slot) begin
      dist_wide = {1'b0, step} - {1'b0, cur_slot} - (SW+1)'(1);
    end else begin
      dist_wide = {1'b0, step} + (SW+1)'(TASK_SLOTS - 1) - {1'b0, cur_slot};
    end
    rr_dist    = dist_wide[SW-1:0];
    eligible   = (head.state == SLOT_READY) || wait_due;
    better     = !found || (head.priority_lvl > best_pri) ||
                 ((head.priority_lvl == best_pri) && (rr_dist < best_dist));
    slot_match = (CW'(step) == CW'(op_slot));
    cur_match  = cur_valid && (step == cur_slot) && (head.state != SLOT_FREE);
    head_next  = head;
    case (op_action)
      ACT_SCHEDULE: begin
        if (wait_due || head.state == SLOT_YIELD) begin
          head_next.state = SLOT_READY;
        end
      end
      ACT_REMOVE: begin
        if (slot_match) begin
          head_next.state = SLOT_FREE;
        end
      end
      ACT_SLEEP: begin
        if (cur_match) begin
          head_next.state = SLOT_WAIT;
          head_next.wake  = op_wake;
        end
      end
      ACT_YIELD: begin
        if (cur_match) begin
          head_next.state = SLOT_YIELD;
        end
      end
      default: begin
        head_next = head;
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_slot  <= '0;
      cur_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // In the hold state the output register is reloaded instead.
      if (rsp.valid && rsp.ready && state != ST_HOLD) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_action  <= req.action;
            op_id      <= req.task_id;
            op_pri     <= req.task_priority;
            op_slot    <= req.slot;
            op_now     <= req.now_us;
            op_wake    <= req.now_us + req.duration_us;
            step       <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            dup        <= 1'b0;
            hit        <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          case (op_action)
            ACT_SCHEDULE: begin
              if (eligible && better) begin
                found     <= 1'b1;
                best      <= step;
                best_dist <= rr_dist;
                best_id   <= head.id;
                best_pri  <= head.priority_lvl;
              end
            end
            ACT_ADD: begin
              if (head.state == SLOT_FREE && !free_found) begin
                free_found <= 1'b1;
                free_slot  <= step;
              end
              if (head.state != SLOT_FREE && head.id == op_id) begin
                dup <= 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (slot_match && head.state != SLOT_FREE) begin
                hit     <= 1'b1;
                hit_id  <= head.id;
                hit_pri <= head.priority_lvl;
              end
            end
            ACT_SLEEP, ACT_YIELD: begin
              if (cur_match) begin
                hit     <= 1'b1;
                hit_id  <= head.id;
                hit_pri <= head.priority_lvl;
              end
            end
            default: begin
              hit <= 1'b0;
            end
          endcase
          step <= step + SW'(1);
          if (step == LAST) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          case (op_action)
            ACT_SCHEDULE: begin
              if (found) begin
                cur_slot   <= best;
                cur_valid  <= 1'b1;
                res_status <= STAT_OK;
                res_slot   <= SLOT_W'(best);
                res_id     <= best_id;
                res_pri    <= best_pri;
              end else begin
                res_status <= STAT_NONE;
                res_slot   <= SLOT_W'(cur_slot);
                res_id     <= '0;
                res_pri    <= '0;
              end
            end
            ACT_ADD: begin
              if (!free_found) begin
                res_status <= STAT_FULL;
                res_slot   <= '0;
                res_id     <= '0;
                res_pri    <= '0;
              end else if (dup) begin
                res_status <= STAT_ID_TAKEN;
                res_slot   <= '0;
                res_id     <= '0;
                res_pri    <= '0;
              end else begin
                res_status <= STAT_OK;
                res_slot   <= SLOT_W'(free_slot);
                res_id     <= op_id;
                res_pri    <= op_pri;
              end
            end
            ACT_REMOVE: begin
              res_slot <= op_slot;
              if (hit) begin
                res_status <= STAT_OK;
                res_id     <= hit_id;
                res_pri    <= hit_pri;
                if (cur_valid && CW'(cur_slot) == CW'(op_slot)) begin
                  cur_valid <= 1'b0;
                end
              end else begin
                res_status <= STAT_NOT_USED;
                res_id     <= '0;
                res_pri    <= '0;
              end
            end
            ACT_SLEEP, ACT_YIELD: begin
              if (hit) begin
                res_status <= STAT_OK;
                res_slot   <= SLOT_W'(cur_slot);
                res_id     <= hit_id;
                res_pri    <= hit_pri;
              end else begin
                res_status <= STAT_NOT_USED;
                res_slot   <= '0;
                res_id     <= '0;
                res_pri    <= '0;
              end
            end
            default: begin
              res_status <= STAT_OK;
              res_slot   <= '0;
              res_id     <= '0;
              res_pri    <= '0;
            end
          endcase
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.status          <= res_status;
            rsp.chosen_slot     <= res_slot;
            rsp.chosen_id       <= res_id;
            rsp.chosen_priority <= res_pri;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### test/tb_priority_round_robin_task_picker.sv
// Self-checking testbench for the priority round-robin task picker.
// Depends on prrtp_pkg, the prrtp_req_if/prrtp_rsp_if interfaces and the top level.
module tb_priority_round_robin_task_picker;
  import prrtp_pkg::*;

  // Sixteen slots, the default build of the block.
  localparam int SLOTS = DEFAULT_TASK_SLOTS;
  localparam int RANDOM_ITEMS = 1100;
  // The last stretch of the run goes with no idling on either side.
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);
  localparam int MAX_REPORTS = 10;

  // Action codes 5 to 7 have no meaning and must leave the table alone.
  localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;

  // The block folds running into ready. The predictor keeps them apart,
  // because a schedule demotes only the task that is really running.
  typedef enum logic [2:0] {
    PH_FREE,
    PH_READY,
    PH_RUNNING,
    PH_WAITING,
    PH_YIELDING
  } task_phase_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] dur;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
  } outcome_t;

  typedef struct {
    request_t rq;
    bit       typed;
    outcome_t want;
  } directed_row_t;

  logic clk;
  logic rst;

  prrtp_req_if req ();
  prrtp_rsp_if rsp ();

  priority_round_robin_task_picker #(.TASK_SLOTS(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Predictor copy of the task table.
  task_phase_t       phase_q [SLOTS];
  logic [ID_W-1:0]   id_q    [SLOTS];
  logic [PRI_W-1:0]  pri_q   [SLOTS];
  logic [TIME_W-1:0] wake_q  [SLOTS];
  logic [SLOT_W-1:0] cur_slot;
  bit                cur_valid;

  outcome_t          pending_outcomes[$];
  directed_row_t     directed_rows[$];
  int                mismatches;
  bit                idle_allowed;
  logic [TIME_W-1:0] clock_us;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off here if the block stops answering.
  initial begin
    #600000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic outcome_t make_outcome(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] s,
                                            logic [ID_W-1:0] id, logic [PRI_W-1:0] pr);
    outcome_t o;
    o.status = st;
    o.slot   = s;
    o.id     = id;
    o.pri    = pr;
    return o;
  endfunction

  // Applies one accepted request to the table copy and returns the response
  // that the block must give for it.
  function automatic outcome_t apply_task_request(request_t rq);
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] best;
    logic [TIME_W-1:0] gap;
    bit                found;
    int                free_slot;
    begin
      idx = cur_slot;
      best = '0;
      found = 0;
      free_slot = -1;
      case (rq.action)
        ACT_SCHEDULE: begin
          if (cur_valid && phase_q[cur_slot] == PH_RUNNING)
            phase_q[cur_slot] = PH_READY;
          // Scan starts right after the current slot and wraps back to it.
          for (int t = 0; t < SLOTS; t++) begin
            idx = idx + 1'b1;
            if (phase_q[idx] == PH_FREE)
              continue;
            if (phase_q[idx] == PH_WAITING) begin
              gap = wake_q[idx] - rq.now;
              if (gap == '0 || gap[TIME_W-1])
                phase_q[idx] = PH_READY;
            end
            if (phase_q[idx] == PH_READY && (!found || pri_q[idx] > pri_q[best])) begin
              found = 1;
              best = idx;
            end
            // A yielding task loses exactly this one turn.
            if (phase_q[idx] == PH_YIELDING)
              phase_q[idx] = PH_READY;
          end
          if (!found)
            return make_outcome(STAT_NONE, cur_slot, '0, '0);
          cur_slot = best;
          cur_valid = 1;
          phase_q[best] = PH_RUNNING;
          return make_outcome(STAT_OK, best, id_q[best], pri_q[best]);
        end
        ACT_ADD: begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (phase_q[i] == PH_FREE)
              free_slot = i;
          if (free_slot < 0)
            return make_outcome(STAT_FULL, '0, '0, '0);
          for (int i = 0; i < SLOTS; i++)
            if (phase_q[i] != PH_FREE && id_q[i] == rq.id)
              return make_outcome(STAT_ID_TAKEN, '0, '0, '0);
          id_q[free_slot] = rq.id;
          pri_q[free_slot] = rq.pri;
          wake_q[free_slot] = '0;
          phase_q[free_slot] = PH_READY;
          return make_outcome(STAT_OK, free_slot[SLOT_W-1:0], rq.id, rq.pri);
        end
        ACT_REMOVE: begin
          if (phase_q[rq.slot] == PH_FREE)
            return make_outcome(STAT_NOT_USED, rq.slot, '0, '0);
          phase_q[rq.slot] = PH_FREE;
          if (cur_valid && cur_slot == rq.slot)
            cur_valid = 0;
          return make_outcome(STAT_OK, rq.slot, id_q[rq.slot], pri_q[rq.slot]);
        end
        ACT_SLEEP, ACT_YIELD: begin
          if (!cur_valid || phase_q[cur_slot] == PH_FREE)
            return make_outcome(STAT_NOT_USED, '0, '0, '0);
          if (rq.action == ACT_SLEEP) begin
            phase_q[cur_slot] = PH_WAITING;
            wake_q[cur_slot] = rq.now + rq.dur;
          end else begin
            phase_q[cur_slot] = PH_YIELDING;
          end
          return make_outcome(STAT_OK, cur_slot, id_q[cur_slot], pri_q[cur_slot]);
        end
        default: return make_outcome(STAT_OK, '0, '0, '0);
      endcase
    end
  endfunction

  function automatic request_t make_request(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                            logic [PRI_W-1:0] pr, logic [SLOT_W-1:0] s,
                                            logic [TIME_W-1:0] now, logic [TIME_W-1:0] dur);
    request_t rq;
    rq.action = act;
    rq.id     = id;
    rq.pri    = pr;
    rq.slot   = s;
    rq.now    = now;
    rq.dur    = dur;
    return rq;
  endfunction

  // Rows without a typed answer are checked against the predictor alone.
  function automatic void add_row(request_t rq, bit typed = 0,
                                  outcome_t want = '{default: '0});
    directed_row_t r;
    r.rq = rq;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  // Random requests. Ids come mostly from a small pool so that duplicates
  // and table-full cases happen often; every so often a segment leans on
  // adds to fill the table.
  function automatic request_t random_request(int n);
    request_t rq;
    int       pick;
    bit       fill_phase;
    begin
      fill_phase = ((n / 150) % 2) == 1;
      pick = $urandom_range(0, 99);
      if (fill_phase)
        rq.action = (pick < 45) ? ACT_ADD : (pick < 75) ? ACT_SCHEDULE :
                    (pick < 83) ? ACT_REMOVE : (pick < 90) ? ACT_SLEEP :
                    (pick < 97) ? ACT_YIELD :
                    ACT_UNDEF_LO + ACT_W'($urandom_range(0, 2));
      else
        rq.action = (pick < 35) ? ACT_SCHEDULE : (pick < 55) ? ACT_ADD :
                    (pick < 70) ? ACT_REMOVE : (pick < 82) ? ACT_SLEEP :
                    (pick < 95) ? ACT_YIELD :
                    ACT_UNDEF_LO + ACT_W'($urandom_range(0, 2));
      rq.id = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 23)) :
                                            ID_W'($urandom_range(0, 65535));
      rq.pri = ($urandom_range(0, 9) < 6) ? PRI_W'($urandom_range(0, 3)) :
                                             PRI_W'($urandom_range(0, 255));
      rq.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
      // Time mostly creeps forward, with rare jumps anywhere in the range.
      if ($urandom_range(0, 49) == 0)
        clock_us = $urandom;
      else
        clock_us = clock_us + $urandom_range(0, 300);
      rq.now = clock_us;
      pick = $urandom_range(0, 9);
      rq.dur = (pick < 7) ? $urandom_range(0, 1000) : (pick < 9) ? '0 : $urandom;
      return rq;
    end
  endfunction

  // Offers one request and holds it until the block takes it, then records
  // the expected response.
  task automatic send_request(request_t rq, bit typed, outcome_t want);
    outcome_t predicted;
    begin
      if (idle_allowed && $urandom_range(0, 4) == 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      req.valid         <= 1'b1;
      req.action        <= rq.action;
      req.task_id       <= rq.id;
      req.task_priority <= rq.pri;
      req.slot          <= rq.slot;
      req.now_us        <= rq.now;
      req.duration_us   <= rq.dur;
      do @(posedge clk); while (!req.ready);
      predicted = apply_task_request(rq);
      pending_outcomes.push_back(typed ? want : predicted);
    end
  endtask

  // Response side: random stall bursts while idling is allowed.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Every response transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected response: status %0d slot %0d id %h pri %h",
                   rsp.status, rsp.chosen_slot, rsp.chosen_id, rsp.chosen_priority);
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (rsp.status !== exp_o.status || rsp.chosen_slot !== exp_o.slot ||
            rsp.chosen_id !== exp_o.id || rsp.chosen_priority !== exp_o.pri) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected status %0d slot %0d id %h pri %h, got %0d %0d %h %h",
                     exp_o.status, exp_o.slot, exp_o.id, exp_o.pri, rsp.status,
                     rsp.chosen_slot, rsp.chosen_id, rsp.chosen_priority);
        end
      end
    end
  end

  initial begin
    int quiet_from;
    rst = 1'b1;
    req.valid = 1'b0;
    req.action = ACT_SCHEDULE;
    req.task_id = '0;
    req.task_priority = '0;
    req.slot = '0;
    req.now_us = '0;
    req.duration_us = '0;
    mismatches = 0;
    idle_allowed = 1'b1;
    clock_us = '0;
    for (int i = 0; i < SLOTS; i++) begin
      phase_q[i] = PH_FREE;
      id_q[i] = '0;
      pri_q[i] = '0;
      wake_q[i] = '0;
    end
    cur_slot = '0;
    cur_valid = 0;

    // Directed part. With an empty table nothing can run and nothing can
    // sleep or yield; the outcomes there are plain enough to type in.
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 0, 0), 1,
            make_outcome(STAT_NONE, 0, 0, 0));
    add_row(make_request(ACT_SLEEP, 0, 0, 0, 0, 5), 1,
            make_outcome(STAT_NOT_USED, 0, 0, 0));
    add_row(make_request(ACT_YIELD, 0, 0, 0, 0, 0), 1,
            make_outcome(STAT_NOT_USED, 0, 0, 0));
    add_row(make_request(ACT_REMOVE, 0, 0, 4'hF, 0, 0), 1,
            make_outcome(STAT_NOT_USED, 4'hF, 0, 0));
    // Lowest and highest id and priority; priority zero must still run.
    add_row(make_request(ACT_ADD, 16'h0000, 8'h00, 0, 0, 0), 1,
            make_outcome(STAT_OK, 0, 16'h0000, 8'h00));
    add_row(make_request(ACT_ADD, 16'hFFFF, 8'hFF, 0, 0, 0), 1,
            make_outcome(STAT_OK, 1, 16'hFFFF, 8'hFF));
    add_row(make_request(ACT_ADD, 16'hFFFF, 8'h01, 0, 0, 0), 1,
            make_outcome(STAT_ID_TAKEN, 0, 0, 0));
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 0, 0));
    // A yielding task sits out one scan, so the priority-zero task runs.
    add_row(make_request(ACT_YIELD, 0, 0, 0, 0, 0));
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 0, 0));
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 0, 0));
    // Sleep whose wake time wraps past zero.
    add_row(make_request(ACT_SLEEP, 0, 0, 0, 32'hFFFF_FFF0, 32'h20));
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 32'h0000_0000, 0));
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 32'h0000_0010, 0));
    add_row(make_request(ACT_SLEEP, 0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF));
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 32'h7FFF_FFFF, 0));
    add_row(make_request(ACT_UNDEF_LO, 16'h1234, 8'h56, 4'h3, 0, 0), 1,
            make_outcome(STAT_OK, 0, 0, 0));
    add_row(make_request(ACT_UNDEF_HI, 16'hFFFF, 8'hFF, 4'hF, 0, 0), 1,
            make_outcome(STAT_OK, 0, 0, 0));
    add_row(make_request(ACT_REMOVE, 0, 0, 4'h0, 0, 0));
    add_row(make_request(ACT_REMOVE, 0, 0, 4'h1, 0, 0));
    add_row(make_request(ACT_SCHEDULE, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

    quiet_from = RANDOM_ITEMS - QUIET_TAIL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Stretches without idling come now and then, and at the very end.
      idle_allowed = (n < quiet_from) && ((n / 100) % 3 != 2);
      send_request(random_request(n), 0, '{default: '0});
    end
    req.valid <= 1'b0;
    idle_allowed = 1'b0;

    while (pending_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
rtl/prrtp_pkg.sv
rtl/prrtp_if.sv
rtl/prrtp_cell.sv
rtl/priority_round_robin_task_picker.sv
test/tb_priority_round_robin_task_picker.sv
